// ===== rtl/arss_pkg.sv =====
// Shared constants and the arctangent table for the affine rotation, scale and shear split.
// No dependencies.
package arss_pkg;

  localparam int DATA_WIDTH_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int GUARD             = 10;
  localparam int ZW                = 35;
  localparam int ANGLE_W           = 16;
  localparam int ANGLE_SHIFT       = 17;
  localparam int ANGLE_MAX         = 25736;
  localparam int SHEAR_W           = 24;
  localparam int SHEAR_FRAC        = 12;
  localparam int QW                = 24;
  localparam logic [31:0] INVK_Q32 = 32'h9B74EDA8;
  localparam logic signed [ZW-1:0] PI_Q30 = 35'sd3373259426;

  function automatic logic signed [ZW-1:0] atan_q30(input int idx);
    logic [31:0] v;
    begin
      case (idx)
        0: v = 32'd843314856;
        1: v = 32'd497837829;
        2: v = 32'd263043836;
        3: v = 32'd133525158;
        4: v = 32'd67021686;
        5: v = 32'd33543515;
        6: v = 32'd16775850;
        7: v = 32'd8388437;
        8: v = 32'd4194282;
        9: v = 32'd2097149;
        10: v = 32'd1048575;
        11: v = 32'd524287;
        12: v = 32'd262143;
        13: v = 32'd131071;
        14: v = 32'd65535;
        15: v = 32'd32767;
        16: v = 32'd16383;
        17: v = 32'd8191;
        18: v = 32'd4095;
        19: v = 32'd2047;
        20: v = 32'd1023;
        21: v = 32'd511;
        22: v = 32'd255;
        23: v = 32'd127;
        24: v = 32'd63;
        25: v = 32'd31;
        26: v = 32'd15;
        27: v = 32'd7;
        28: v = 32'd3;
        29: v = 32'd1;
        default: v = 32'd0;
      endcase
      atan_q30 = signed'({{(ZW-32){1'b0}}, v});
    end
  endfunction

endpackage

// ===== rtl/arss_cordic_stage.sv =====
// One registered CORDIC vectoring micro-rotation of both columns, or pass-through.
// Depends on arss_pkg for the arctangent table.
module arss_cordic_stage
  import arss_pkg::*;
#(
  parameter int IW  = 29,
  parameter int IDX = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 v_i,
  input  logic                 byp_i,
  input  logic signed [IW-1:0] x_i,
  input  logic signed [IW-1:0] y_i,
  input  logic signed [IW-1:0] u_i,
  input  logic signed [IW-1:0] w_i,
  input  logic signed [ZW-1:0] z_i,
  output logic                 v_o,
  output logic                 byp_o,
  output logic signed [IW-1:0] x_o,
  output logic signed [IW-1:0] y_o,
  output logic signed [IW-1:0] u_o,
  output logic signed [IW-1:0] w_o,
  output logic signed [ZW-1:0] z_o
);

  logic                 v_r;
  logic                 byp_r;
  logic signed [IW-1:0] x_r, y_r, u_r, w_r;
  logic signed [ZW-1:0] z_r;
  logic signed [IW-1:0] x_nxt, y_nxt, u_nxt, w_nxt;
  logic signed [ZW-1:0] z_nxt;

  always_comb begin
    x_nxt = x_i;
    y_nxt = y_i;
    u_nxt = u_i;
    w_nxt = w_i;
    z_nxt = z_i;
    if (!byp_i) begin
      if (!y_i[IW-1]) begin
        x_nxt = x_i + (y_i >>> IDX);
        y_nxt = y_i - (x_i >>> IDX);
        u_nxt = u_i + (w_i >>> IDX);
        w_nxt = w_i - (u_i >>> IDX);
        z_nxt = z_i + atan_q30(IDX);
      end else begin
        x_nxt = x_i - (y_i >>> IDX);
        y_nxt = y_i + (x_i >>> IDX);
        u_nxt = u_i - (w_i >>> IDX);
        w_nxt = w_i + (u_i >>> IDX);
        z_nxt = z_i - atan_q30(IDX);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      byp_r <= byp_i;
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      u_r   <= u_nxt;
      w_r   <= w_nxt;
      z_r   <= z_nxt;
    end
  end

  assign v_o   = v_r;
  assign byp_o = byp_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign u_o   = u_r;
  assign w_o   = w_r;
  assign z_o   = z_r;

endmodule

// ===== rtl/arss_div_stage.sv =====
// One registered restoring-division step that settles a single quotient bit.
// Depends on arss_pkg for the quotient width.
module arss_div_stage
  import arss_pkg::*;
#(
  parameter int RW  = 54,
  parameter int DW  = 29,
  parameter int PW  = 8,
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          v_i,
  input  logic [RW-1:0] rem_i,
  input  logic [DW-1:0] den_i,
  input  logic [QW-1:0] q_i,
  input  logic [PW-1:0] pay_i,
  output logic          v_o,
  output logic [RW-1:0] rem_o,
  output logic [DW-1:0] den_o,
  output logic [QW-1:0] q_o,
  output logic [PW-1:0] pay_o
);

  logic          v_r;
  logic [RW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [QW-1:0] q_r;
  logic [PW-1:0] pay_r;
  logic [RW-1:0] sub;
  logic [RW-1:0] rem_nxt;
  logic [QW-1:0] q_nxt;

  always_comb begin
    sub     = {{(RW-DW){1'b0}}, den_i} << BIT;
    rem_nxt = rem_i;
    q_nxt   = q_i;
    if (rem_i >= sub) begin
      rem_nxt  = rem_i - sub;
      q_nxt[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      den_r <= den_i;
      q_r   <= q_nxt;
      pay_r <= pay_i;
    end
  end

  assign v_o   = v_r;
  assign rem_o = rem_r;
  assign den_o = den_r;
  assign q_o   = q_r;
  assign pay_o = pay_r;

endmodule

// ===== rtl/affine_rotation_scale_shear_split_top.sv =====
// Top level of the affine rotation, scale and shear split.
// Depends on arss_pkg, arss_cordic_stage and arss_div_stage.
//
// Input channel: one transfer carries the four entries a11, a12, a21, a22 of the
// linear part of a 2D affine matrix. Output channel: one transfer per matrix with
// angle, scale_x, scale_y and shear_x in out_tdata and shear_invalid in out_tuser.
// The angle and x scale come from a CORDIC in vectoring mode on the first column;
// the second column follows the same micro-rotations. Shear is found by a
// restoring divider that settles one quotient bit per stage.
// From input transfer to output valid, an item passes one entry stage, one
// stage per CORDIC step, two gain and rounding stages, 24 divider stages and
// the output register. Throughput is one matrix per cycle when the receiver
// does not stall; every stage is registered. While the receiver stalls, the
// whole pipeline holds and in_tready is low; no item is lost or repeated. A
// synchronous reset clears all valid bits, so the output channel is empty
// after reset.
module affine_rotation_scale_shear_split_top
  import arss_pkg::*;
#(
  parameter int DATA_WIDTH    = DATA_WIDTH_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  // a11, a12, a21, a22 from the lowest bit up, zero padding above
  input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]        in_tdata,
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  // angle, scale_x, scale_y, shear_x from the lowest bit up, zero padding above
  output logic [((2*DATA_WIDTH+41+7)/8)*8-1:0]     out_tdata,
  // shear_invalid
  output logic                                     out_tuser
);

  localparam int DW   = DATA_WIDTH;
  localparam int IW   = DW + GUARD + 3;
  localparam int RW   = IW + QW + 1;
  localparam int PRW  = IW + 32;
  localparam int PW   = ANGLE_W + DW + (DW + 1) + 3;
  localparam int IN_W = ((4*DW+7)/8)*8;
  localparam int OUT_W = ((2*DW+41+7)/8)*8;
  localparam logic [DW:0] LIM = {1'b0, {DW{1'b1}}};

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // Entry stage.
  logic signed [DW-1:0] a11, a12, a21, a22;
  logic signed [IW-1:0] x0, y0, u0, w0;
  logic signed [ZW-1:0] z0;
  logic                 byp0;

  assign a11 = in_tdata[DW-1:0];
  assign a12 = in_tdata[2*DW-1:DW];
  assign a21 = in_tdata[3*DW-1:2*DW];
  assign a22 = in_tdata[4*DW-1:3*DW];

  always_comb begin
    x0 = IW'(a11) <<< GUARD;
    y0 = IW'(a21) <<< GUARD;
    u0 = IW'(a12) <<< GUARD;
    w0 = IW'(a22) <<< GUARD;
    z0 = '0;
    byp0 = (a11 == '0) && (a21 == '0);
    if (a11[DW-1]) begin
      x0 = -x0;
      y0 = -y0;
      u0 = -u0;
      w0 = -w0;
      z0 = a21[DW-1] ? -PI_Q30 : PI_Q30;
    end
  end

  logic                 cv   [CORDIC_STAGES+1];
  logic                 cb   [CORDIC_STAGES+1];
  logic signed [IW-1:0] cx   [CORDIC_STAGES+1];
  logic signed [IW-1:0] cy   [CORDIC_STAGES+1];
  logic signed [IW-1:0] cu   [CORDIC_STAGES+1];
  logic signed [IW-1:0] cw   [CORDIC_STAGES+1];
  logic signed [ZW-1:0] cz   [CORDIC_STAGES+1];

  logic                 e_v_r, e_b_r;
  logic signed [IW-1:0] e_x_r, e_y_r, e_u_r, e_w_r;
  logic signed [ZW-1:0] e_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else if (en) begin
      e_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_b_r <= byp0;
      e_x_r <= x0;
      e_y_r <= y0;
      e_u_r <= u0;
      e_w_r <= w0;
      e_z_r <= z0;
    end
  end

  assign cv[0] = e_v_r;
  assign cb[0] = e_b_r;
  assign cx[0] = e_x_r;
  assign cy[0] = e_y_r;
  assign cu[0] = e_u_r;
  assign cw[0] = e_w_r;
  assign cz[0] = e_z_r;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    arss_cordic_stage #(.IW(IW), .IDX(i)) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .v_i   (cv[i]),
      .byp_i (cb[i]),
      .x_i   (cx[i]),
      .y_i   (cy[i]),
      .u_i   (cu[i]),
      .w_i   (cw[i]),
      .z_i   (cz[i]),
      .v_o   (cv[i+1]),
      .byp_o (cb[i+1]),
      .x_o   (cx[i+1]),
      .y_o   (cy[i+1]),
      .u_o   (cu[i+1]),
      .w_o   (cw[i+1]),
      .z_o   (cz[i+1])
    );
  end

  // Gain stage: multiply by 1/K and round the angle.
  logic signed [IW-1:0] fx, fu, fw;
  logic signed [ZW-1:0] fz;
  logic                 fb;
  logic [IW-1:0]        mx, mu, mw;
  logic [ZW-1:0]        mz, amr;
  logic [ANGLE_W-1:0]   ang_nxt;

  assign fx = cx[CORDIC_STAGES];
  assign fu = cu[CORDIC_STAGES];
  assign fw = cw[CORDIC_STAGES];
  assign fz = cz[CORDIC_STAGES];
  assign fb = cb[CORDIC_STAGES];

  always_comb begin
    mx  = (fx > 0) ? fx : '0;
    mu  = fu[IW-1] ? -fu : fu;
    mw  = fw[IW-1] ? -fw : fw;
    mz  = fz[ZW-1] ? -fz : fz;
    amr = (mz + (ZW'(1) << (ANGLE_SHIFT-1))) >> ANGLE_SHIFT;
    if (amr > ZW'(ANGLE_MAX)) begin
      amr = ZW'(ANGLE_MAX);
    end
    ang_nxt = fz[ZW-1] ? -amr[ANGLE_W-1:0] : amr[ANGLE_W-1:0];
  end

  logic               g_v_r, g_b_r, g_wn_r, g_neg_r;
  logic [PRW-1:0]     g_px_r, g_py_r;
  logic [IW-1:0]      g_mu_r, g_mw_r;
  logic [ANGLE_W-1:0] g_ang_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_v_r <= 1'b0;
    end else if (en) begin
      g_v_r <= cv[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_b_r   <= fb;
      g_px_r  <= PRW'(mx) * PRW'(INVK_Q32);
      g_py_r  <= PRW'(mw) * PRW'(INVK_Q32);
      g_mu_r  <= mu;
      g_mw_r  <= mw;
      g_wn_r  <= fw[IW-1];
      g_neg_r <= fu[IW-1] != fw[IW-1];
      g_ang_r <= ang_nxt;
    end
  end

  // Rounding stage: drop guard bits, saturate, set up the division.
  logic [PRW-1:0]     tx, ty, sxw, syw;
  logic [DW:0]        sxo, syo;
  logic [DW:0]        syv;
  logic               inval;
  logic [RW-1:0]      num;
  logic               sat;
  logic [PW-1:0]      pay0;

  always_comb begin
    tx  = (g_px_r >> 32) + (PRW'(1) << (GUARD-1));
    ty  = g_b_r ? PRW'(g_mw_r) + (PRW'(1) << (GUARD-1))
                : (g_py_r >> 32) + (PRW'(1) << (GUARD-1));
    sxw = g_b_r ? '0 : tx >> GUARD;
    syw = ty >> GUARD;
    sxo = (sxw > PRW'(LIM)) ? LIM : sxw[DW:0];
    syo = (syw > PRW'(LIM)) ? LIM : syw[DW:0];
    syv = g_wn_r ? -syo : syo;
    inval = (syo == '0);
    num = (RW'(g_mu_r) << SHEAR_FRAC) + (RW'(g_mw_r) >> 1);
    sat = num >= (RW'(g_mw_r) << QW);
    pay0 = {sat, inval, g_neg_r, syv, sxo[DW-1:0], g_ang_r};
  end

  logic          dv  [QW+1];
  logic [RW-1:0] dr  [QW+1];
  logic [IW-1:0] dd  [QW+1];
  logic [QW-1:0] dq  [QW+1];
  logic [PW-1:0] dp  [QW+1];

  logic          r_v_r;
  logic [RW-1:0] r_rem_r;
  logic [IW-1:0] r_den_r;
  logic [PW-1:0] r_pay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_v_r <= 1'b0;
    end else if (en) begin
      r_v_r <= g_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_rem_r <= num;
      r_den_r <= g_mw_r;
      r_pay_r <= pay0;
    end
  end

  assign dv[0] = r_v_r;
  assign dr[0] = r_rem_r;
  assign dd[0] = r_den_r;
  assign dq[0] = '0;
  assign dp[0] = r_pay_r;

  for (genvar k = 0; k < QW; k++) begin : g_div
    arss_div_stage #(.RW(RW), .DW(IW), .PW(PW), .BIT(QW-1-k)) u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .v_i   (dv[k]),
      .rem_i (dr[k]),
      .den_i (dd[k]),
      .q_i   (dq[k]),
      .pay_i (dp[k]),
      .v_o   (dv[k+1]),
      .rem_o (dr[k+1]),
      .den_o (dd[k+1]),
      .q_o   (dq[k+1]),
      .pay_o (dp[k+1])
    );
  end

  // Output stage: sign and saturate the shear, or zero it when invalid.
  logic [PW-1:0]      fp;
  logic               f_sat, f_inval, f_neg;
  logic [QW:0]        qx;
  logic [SHEAR_W-1:0] sh_nxt;

  assign fp      = dp[QW];
  assign f_sat   = fp[PW-1];
  assign f_inval = fp[PW-2];
  assign f_neg   = fp[PW-3];

  always_comb begin
    qx = f_sat ? {1'b1, {QW{1'b0}}} : {1'b0, dq[QW]};
    if (f_inval) begin
      sh_nxt = '0;
    end else if (f_neg) begin
      if (qx > (QW+1)'(1 << (SHEAR_W-1))) begin
        qx = (QW+1)'(1 << (SHEAR_W-1));
      end
      sh_nxt = -qx[SHEAR_W-1:0];
    end else begin
      if (qx > (QW+1)'((1 << (SHEAR_W-1)) - 1)) begin
        qx = (QW+1)'((1 << (SHEAR_W-1)) - 1);
      end
      sh_nxt = qx[SHEAR_W-1:0];
    end
  end

  logic             o_v_r;
  logic [OUT_W-1:0] o_data_r;
  logic             o_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (en) begin
      o_v_r <= dv[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_data_r <= OUT_W'({sh_nxt, fp[PW-4:0]});
      o_user_r <= f_inval;
    end
  end

  assign out_tvalid = o_v_r;
  assign out_tdata  = o_data_r;
  assign out_tuser  = o_user_r;

  logic unused_in;
  assign unused_in = ^{in_tdata >> (4*DW), 1'b0} ^ ^dr[QW] ^ ^dd[QW];

endmodule

// ===== rtl/arss_checker.sv =====
// Port-level checks on the output channel of the affine rotation, scale and shear split.
// Depends on arss_pkg and binds to affine_rotation_scale_shear_split_top.
module arss_checker
  import arss_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [((2*DATA_WIDTH+41+7)/8)*8-1:0] out_tdata,
  input logic                                 out_tuser
);

  localparam int DW = DATA_WIDTH;

  logic signed [ANGLE_W-1:0] ang;
  logic [DW:0]               sy;
  logic [SHEAR_W-1:0]        sh;

  assign ang = out_tdata[ANGLE_W-1:0];
  assign sy  = out_tdata[ANGLE_W+2*DW:ANGLE_W+DW];
  assign sh  = out_tdata[ANGLE_W+2*DW+SHEAR_W:ANGLE_W+2*DW+1];

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("Stalled output transfer changed.");

  a_inval: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> sy == '0 && sh == '0)
    else $error("Invalid shear with non-zero y scale or shear.");

  a_valid_sy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> sy != '0)
    else $error("Zero y scale without the invalid flag.");

  a_angle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ang <= ANGLE_W'(ANGLE_MAX) && ang >= -ANGLE_W'(ANGLE_MAX))
    else $error("Angle outside minus pi to pi.");

endmodule

bind affine_rotation_scale_shear_split_top arss_checker #(.DATA_WIDTH(DATA_WIDTH)) u_arss_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
